/* rtl/afr_pkg.sv */
// Shared constants for the addressed frame receiver.
`default_nettype none

package afr_pkg;

   localparam int BUFFER_DEPTH = 256;
   localparam int STORE_LIMIT  = (BUFFER_DEPTH > 255) ? 255 : BUFFER_DEPTH;
   localparam logic [7:0] STORE_LIMIT_B = 8'(STORE_LIMIT);
   localparam logic [7:0] CHECK_BYTES   = 8'd2;

   // register indexes on the csr port
   localparam logic [1:0] CSR_HEADER_BYTE     = 2'd0;
   localparam logic [1:0] CSR_END_BYTE        = 2'd1;
   localparam logic [1:0] CSR_ADDRESS_LENGTH  = 2'd2;
   localparam logic [1:0] CSR_MAX_DATA_LENGTH = 2'd3;

   // input commands
   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_REARM = 1'b1;

   typedef struct packed {
      logic       store_enable;
      logic [7:0] store_index;
      logic [7:0] store_byte;
      logic       frame_done;
      logic [7:0] frame_length;
      logic       frame_abort;
      logic       timeout_armed;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/addressed_frame_receiver.sv */
// Addressed, length-prefixed frame receiver: one byte per item, buffer writes out.
//
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | req_cmd, req_byte_in
//  rsp     | out       | rsp_valid/stall  | rsp_store_*, rsp_frame_*, rsp_timeout_armed
//  csr     | in        | csr_valid/ready  | csr_index, csr_data
//
// One item per clock while req_stall is low; the result appears in the output
// register in the cycle after acceptance. req_stall is raised only while a held
// result is stalled. Synchronous active-high reset returns to header hunt with
// default registers. The csr port is always ready.
`default_nettype none

module addressed_frame_receiver
   import afr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic       req_cmd,
   input  wire logic [7:0] req_byte_in,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       rsp_store_enable,
   output      logic [7:0] rsp_store_index,
   output      logic [7:0] rsp_store_byte,
   output      logic       rsp_frame_done,
   output      logic [7:0] rsp_frame_length,
   output      logic       rsp_frame_abort,
   output      logic       rsp_timeout_armed,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_data
);

   localparam logic [3:0] PH_HUNT  = 4'd0;
   localparam logic [3:0] PH_ADDR  = 4'd1;
   localparam logic [3:0] PH_SEQ   = 4'd2;
   localparam logic [3:0] PH_CMD   = 4'd3;
   localparam logic [3:0] PH_LEN   = 4'd4;
   localparam logic [3:0] PH_DATA  = 4'd5;
   localparam logic [3:0] PH_CHECK = 4'd6;
   localparam logic [3:0] PH_END   = 4'd7;
   localparam logic [3:0] PH_DONE  = 4'd8;

   logic [7:0] header_byte_ff, end_byte_ff, max_data_length_ff;
   logic [3:0] address_length_ff;

   logic [3:0] phase_ff, phase_in;
   logic [7:0] stored_count_ff, stored_count_in;
   logic [7:0] field_count_ff, field_count_in;
   logic [7:0] data_length_ff, data_length_in;
   logic       receiving_ff, receiving_in;

   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       accept;
   logic       overflow;
   logic [7:0] field_next;
   logic       stored, aborted;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign overflow   = stored_count_ff >= STORE_LIMIT_B;
   assign field_next = field_count_ff + 8'd1;

   always_comb begin
      phase_in        = phase_ff;
      stored_count_in = stored_count_ff;
      field_count_in  = field_count_ff;
      data_length_in  = data_length_ff;
      receiving_in    = receiving_ff;
      stored          = 1'b0;
      aborted         = 1'b0;

      if (req_cmd == CMD_REARM) begin
         phase_in        = PH_HUNT;
         stored_count_in = 8'd0;
         field_count_in  = 8'd0;
         receiving_in    = 1'b0;
      end else begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_byte_in == header_byte_ff) begin
                  stored          = 1'b1;
                  stored_count_in = 8'd1;
                  field_count_in  = 8'd0;
                  receiving_in    = 1'b1;
                  phase_in        = PH_ADDR;
               end
            end
            PH_ADDR, PH_SEQ, PH_CMD, PH_LEN, PH_DATA, PH_CHECK, PH_END: begin
               if ((phase_ff == PH_LEN && req_byte_in > max_data_length_ff) ||
                   (phase_ff == PH_END && req_byte_in != end_byte_ff) || overflow) begin
                  aborted         = 1'b1;
                  phase_in        = PH_HUNT;
                  stored_count_in = 8'd0;
                  field_count_in  = 8'd0;
                  receiving_in    = 1'b0;
               end else begin
                  stored          = 1'b1;
                  stored_count_in = stored_count_ff + 8'd1;
                  unique case (phase_ff)
                     PH_ADDR: begin
                        field_count_in = field_next;
                        if (field_next >= {4'd0, address_length_ff}) phase_in = PH_SEQ;
                     end
                     PH_SEQ: phase_in = PH_CMD;
                     PH_CMD: phase_in = PH_LEN;
                     PH_LEN: begin
                        data_length_in = req_byte_in;
                        field_count_in = 8'd0;
                        phase_in       = (req_byte_in == 8'd0) ? PH_CHECK : PH_DATA;
                     end
                     PH_DATA: begin
                        if (field_next >= data_length_ff) begin
                           field_count_in = 8'd0;
                           phase_in       = PH_CHECK;
                        end else begin
                           field_count_in = field_next;
                        end
                     end
                     PH_CHECK: begin
                        field_count_in = field_next;
                        if (field_next >= CHECK_BYTES) phase_in = PH_END;
                     end
                     default: begin
                        receiving_in = 1'b0;
                        phase_in     = PH_DONE;
                     end
                  endcase
               end
            end
            PH_DONE: ;
            default: begin
               phase_in     = PH_HUNT;
               receiving_in = 1'b0;
            end
         endcase
      end

      rsp_in.store_enable  = stored;
      rsp_in.store_index   = stored ? stored_count_ff & {8{phase_ff != PH_HUNT}} : 8'd0;
      rsp_in.store_byte    = stored ? req_byte_in : 8'd0;
      rsp_in.frame_done    = phase_in == PH_DONE;
      rsp_in.frame_length  = stored_count_in;
      rsp_in.frame_abort   = aborted;
      rsp_in.timeout_armed = receiving_in;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_HUNT;
         stored_count_ff    <= 8'd0;
         field_count_ff     <= 8'd0;
         data_length_ff     <= 8'd0;
         receiving_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         header_byte_ff     <= 8'd0;
         end_byte_ff        <= 8'd83;
         address_length_ff  <= 4'd4;
         max_data_length_ff <= 8'd240;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff        <= phase_in;
            stored_count_ff <= stored_count_in;
            field_count_ff  <= field_count_in;
            data_length_ff  <= data_length_in;
            receiving_ff    <= receiving_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_HEADER_BYTE:     header_byte_ff     <= csr_data;
               CSR_END_BYTE:        end_byte_ff        <= csr_data;
               CSR_ADDRESS_LENGTH:  address_length_ff  <= csr_data[3:0];
               CSR_MAX_DATA_LENGTH: max_data_length_ff <= csr_data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_store_enable  = rsp_ff.store_enable;
   assign rsp_store_index   = rsp_ff.store_index;
   assign rsp_store_byte    = rsp_ff.store_byte;
   assign rsp_frame_done    = rsp_ff.frame_done;
   assign rsp_frame_length  = rsp_ff.frame_length;
   assign rsp_frame_abort   = rsp_ff.frame_abort;
   assign rsp_timeout_armed = rsp_ff.timeout_armed;

endmodule

`default_nettype wire
